FILE: rtl/bba_pkg.sv
// Package for the block bitmap allocator: sizes, operation codes and the
// structs passed between the sequencer and the word scan unit. No dependencies.
`default_nettype none

package bba_pkg;

    // bitmap geometry
    localparam int MAX_BITS  = 4096;
    localparam int WORD_BITS = 64;
    localparam int WORDS     = MAX_BITS / WORD_BITS;
    localparam int ADDR_W    = $clog2(WORDS);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int POS_W     = 12;
    localparam int CNT_W     = 13;
    localparam int BYTE_W    = 8;

    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(4096);
    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_BITS);

    // request codes
    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // what the scan unit needs to know about the current word
    typedef struct packed {
        logic [ADDR_W-1:0] cur_word;
        logic [ADDR_W-1:0] start_word;
        logic [BIT_W-1:0]  start_bit;
        logic [ADDR_W-1:0] last_word;
        logic [BIT_W-1:0]  last_bit;
        logic              want;
    } scan_req_t;

    typedef struct packed {
        logic             hit;
        logic [BIT_W-1:0] index;
    } scan_res_t;

    // one result item
    typedef struct packed {
        logic              error;
        logic              bit_read;
        logic [POS_W-1:0]  found;
        logic [BYTE_W-1:0] ubyte;
    } res_t;

endpackage

`default_nettype wire

FILE: rtl/bba_store.sv
// Bitmap word store: 64-bit word memory with one read and one write port,
// registered read data, and per-word valid bits so reset reads as zeros. Uses bba_pkg.
`default_nettype none

module bba_store (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        wr_en,
    input  wire logic [bba_pkg::ADDR_W-1:0]  wr_addr,
    input  wire logic [bba_pkg::WORD_BITS-1:0] wr_data,
    input  wire logic [bba_pkg::ADDR_W-1:0]  rd_addr,
    output logic [bba_pkg::WORD_BITS-1:0]    rd_data
);

    logic [bba_pkg::WORD_BITS-1:0] mem [bba_pkg::WORDS];
    logic [bba_pkg::WORDS-1:0]     valid_reg;
    logic [bba_pkg::WORD_BITS-1:0] rd_word_reg;
    logic                          rd_valid_reg;

    // memory array, no reset
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_word_reg <= mem[rd_addr];
    end

    // valid bits: a word never written since reset reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

`default_nettype wire

FILE: rtl/bba_scan.sv
// Word scan unit: masks one bitmap word to the search window and finds the
// lowest bit equal to the wanted value. Uses bba_pkg.
`default_nettype none

module bba_scan (
    input  wire logic [bba_pkg::WORD_BITS-1:0] word,
    input  wire bba_pkg::scan_req_t            req,
    output bba_pkg::scan_res_t                 res
);

    logic [bba_pkg::WORD_BITS-1:0] lo_mask;
    logic [bba_pkg::WORD_BITS-1:0] hi_mask;
    logic [bba_pkg::WORD_BITS-1:0] match;
    logic [bba_pkg::BIT_W-1:0]     hi_shift;

    // window: bits at or after the start, at or before the last valid bit
    always_comb begin
        hi_shift = bba_pkg::BIT_W'(bba_pkg::WORD_BITS - 1) - req.last_bit;
        lo_mask  = '1;
        hi_mask  = '1;
        if (req.cur_word == req.start_word) begin
            lo_mask = {bba_pkg::WORD_BITS{1'b1}} << req.start_bit;
        end
        if (req.cur_word == req.last_word) begin
            hi_mask = {bba_pkg::WORD_BITS{1'b1}} >> hi_shift;
        end
        match = ~(word ^ {bba_pkg::WORD_BITS{req.want}}) & lo_mask & hi_mask;
    end

    // lowest set bit of the match vector
    always_comb begin
        res.hit   = |match;
        res.index = '0;
        for (int i = bba_pkg::WORD_BITS - 1; i >= 0; i--) begin
            if (match[i]) begin
                res.index = bba_pkg::BIT_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/block_bitmap_allocator.sv
// Block bitmap allocator: a 4096-bit allocation bitmap held as 64 words of 64 bits.
// Requests read a bit, write a bit (returning the updated byte) or search upward
// from a start position for the first bit equal to a wanted value. A read or a
// write passes through the check and finish states to the output register; a
// search reads one memory word a cycle through the single read port, visiting
// 1 to 64 words. Out-of-range positions and unknown operations skip the check
// state and give an error. The input is not ready while a request is in work; a
// finished result waits in an output register while the next request is taken.
// The bitmap reads as all zeros after reset, with no clearing pass. bits_in_use
// is written through the APB port at address 0; the user must do so only while the
// block is idle, as the block does not enforce it. Depends on bba_pkg, bba_store and bba_scan.
`default_nettype none

module block_bitmap_allocator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [11:0] position, [12] wanted_value, rest zero
    input  wire logic [1:0]  s_tuser,   // [1:0] operation
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [0] bit_read, [12:1] found_position,
                                        // [20:13] updated_byte, rest zero
    output logic [0:0]       m_tuser,   // [0] error
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int ADDR_W = bba_pkg::ADDR_W;
    localparam int BIT_W  = bba_pkg::BIT_W;
    localparam int POS_W  = bba_pkg::POS_W;
    localparam int CNT_W  = bba_pkg::CNT_W;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_CHECK  = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    localparam logic [1:0] ADDR_BITS_IN_USE = 2'd0;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         bits_in_use_reg;
    bba_pkg::op_t             op_reg, op_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic                     want_reg, want_next;
    logic [ADDR_W-1:0]        chk_reg, chk_next;
    logic [ADDR_W-1:0]        last_word_reg, last_word_next;
    logic [BIT_W-1:0]         last_bit_reg, last_bit_next;
    bba_pkg::res_t            res_reg, res_next;
    bba_pkg::res_t            m_res_reg;
    logic                     m_valid_reg;

    logic [CNT_W-1:0]         limit;
    logic [CNT_W-1:0]         limit_m1;
    logic [POS_W-1:0]         s_pos;
    bba_pkg::op_t             s_op;
    logic                     s_xfer;
    logic                     in_range;
    logic                     out_load;

    logic                        wr_en;
    logic [bba_pkg::WORD_BITS-1:0] wr_word;
    logic [ADDR_W-1:0]           rd_addr;
    logic [bba_pkg::WORD_BITS-1:0] rd_data;
    bba_pkg::scan_req_t          scan_req;
    bba_pkg::scan_res_t          scan_res;

    // configuration register
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_in_use_reg <= bba_pkg::CNT_RESET;
        end else if (psel && penable && pwrite && (paddr == ADDR_BITS_IN_USE)) begin
            bits_in_use_reg <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = (paddr == ADDR_BITS_IN_USE) ? {{(32 - CNT_W){1'b0}}, bits_in_use_reg}
                                                : '0;

    // effective limit, capped at store capacity
    assign limit    = (bits_in_use_reg > bba_pkg::CNT_MAX) ? bba_pkg::CNT_MAX
                                                           : bits_in_use_reg;
    assign limit_m1 = limit - CNT_W'(1);

    assign s_pos    = s_tdata[POS_W-1:0];
    assign s_op     = bba_pkg::op_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign in_range = {1'b0, s_pos} < limit;

    // output slot free or being emptied
    assign out_load = (state_reg == ST_FINISH) && (!m_valid_reg || m_tready);

    // read address: first word on transfer, then the word after the one checked
    assign rd_addr = (state_reg == ST_IDLE) ? s_pos[POS_W-1:BIT_W]
                                            : ADDR_W'(chk_reg + ADDR_W'(1));

    // read-modify-write of one bit
    always_comb begin
        wr_word = rd_data;
        wr_word[pos_reg[BIT_W-1:0]] = want_reg;
    end

    assign wr_en = (state_reg == ST_CHECK) && (op_reg == bba_pkg::OP_WRITE);

    bba_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (chk_reg),
        .wr_data (wr_word),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // search window for the word being checked
    always_comb begin
        scan_req.cur_word   = chk_reg;
        scan_req.start_word = pos_reg[POS_W-1:BIT_W];
        scan_req.start_bit  = pos_reg[BIT_W-1:0];
        scan_req.last_word  = last_word_reg;
        scan_req.last_bit   = last_bit_reg;
        scan_req.want       = want_reg;
    end

    bba_scan u_scan (
        .word (rd_data),
        .req  (scan_req),
        .res  (scan_res)
    );

    // sequencer
    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        want_next      = want_reg;
        chk_next       = chk_reg;
        last_word_next = last_word_reg;
        last_bit_next  = last_bit_reg;
        res_next       = res_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    op_next        = s_op;
                    pos_next       = s_pos;
                    want_next      = s_tdata[POS_W];
                    chk_next       = s_pos[POS_W-1:BIT_W];
                    last_word_next = limit_m1[POS_W-1:BIT_W];
                    last_bit_next  = limit_m1[BIT_W-1:0];
                    res_next       = '0;
                    if ((s_op == bba_pkg::OP_NONE) || !in_range) begin
                        res_next.error = 1'b1;
                        state_next     = ST_FINISH;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                case (op_reg)
                    bba_pkg::OP_READ: begin
                        res_next.bit_read = rd_data[pos_reg[BIT_W-1:0]];
                        state_next        = ST_FINISH;
                    end
                    bba_pkg::OP_WRITE: begin
                        res_next.ubyte = wr_word[{pos_reg[BIT_W-1:3], 3'b000} +: 8];
                        state_next     = ST_FINISH;
                    end
                    bba_pkg::OP_SEARCH: begin
                        if (scan_res.hit) begin
                            res_next.found = {chk_reg, scan_res.index};
                            state_next     = ST_FINISH;
                        end else if (chk_reg == last_word_reg) begin
                            res_next.error = 1'b1;
                            state_next     = ST_FINISH;
                        end else begin
                            chk_next = ADDR_W'(chk_reg + ADDR_W'(1));
                        end
                    end
                    default: begin
                        res_next.error = 1'b1;
                        state_next     = ST_FINISH;
                    end
                endcase
            end
            ST_FINISH: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        pos_reg       <= pos_next;
        want_reg      <= want_next;
        chk_reg       <= chk_next;
        last_word_reg <= last_word_next;
        last_bit_reg  <= last_bit_next;
        res_reg       <= res_next;
        if (out_load) begin
            m_res_reg <= res_reg;
        end
    end

    // result transfer
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.error;
    assign m_tdata  = {3'b000, m_res_reg.ubyte, m_res_reg.found, m_res_reg.bit_read};

endmodule

`default_nettype wire

FILE: dv/bba_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the block bitmap allocator: watches the request, result and APB
// channels, keeps a private bitmap and bit count, and checks every result in order.
// Depends on bba_pkg.

module bba_checker #(
    parameter logic [1:0] LIMIT_ADDR = '0
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,    // [11:0] position, [12] wanted_value
    input  logic [1:0]  s_tuser,    // [1:0] operation
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,    // [0] bit_read, [12:1] found_position, [20:13] updated_byte
    input  logic [0:0]  m_tuser,    // [0] error
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);

    logic [bba_pkg::MAX_BITS-1:0] bitmap;
    logic [bba_pkg::CNT_W-1:0]    bits_in_use;
    bba_pkg::res_t                expected_results[$];
    int                           fails = 0;
    int                           n_req = 0;
    int                           n_res = 0;

    assign fail_count = fails;
    assign pending    = n_req - n_res;

    task automatic report_mismatch(input string what, input int got, input int want);
        fails++;
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Apply one request to the private bitmap and return the result it should give.
    function automatic bba_pkg::res_t bitmap_apply(bba_pkg::op_t op, logic [11:0] pos,
                                                   logic want);
        bba_pkg::res_t r;
        int            lim;
        int            p;
        r       = '0;
        r.error = 1'b1;
        // a count above capacity acts as full capacity
        lim = (bits_in_use > bba_pkg::CNT_MAX) ? bba_pkg::MAX_BITS : int'(bits_in_use);
        case (op)
            bba_pkg::OP_READ: begin
                if (int'(pos) < lim) begin
                    r.error    = 1'b0;
                    r.bit_read = bitmap[pos];
                end
            end
            bba_pkg::OP_WRITE: begin
                if (int'(pos) < lim) begin
                    bitmap[pos] = want;
                    r.error     = 1'b0;
                    r.ubyte     = bitmap[{pos[11:3], 3'b000} +: 8];
                end
            end
            bba_pkg::OP_SEARCH: begin
                // start at or past the limit scans nothing and stays an error
                for (p = int'(pos); p < lim && r.error; p++) begin
                    if (bitmap[p] == want) begin
                        r.error = 1'b0;
                        r.found = 12'(p);
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        bba_pkg::res_t got;
        bba_pkg::res_t want_r;
        if (!aresetn) begin
            bitmap      = '0;
            bits_in_use = bba_pkg::CNT_RESET;
            expected_results.delete();
            n_req <= 0;
            n_res <= 0;
        end else begin
            // register traffic: track writes, check readback
            if (psel && penable && pready && paddr == LIMIT_ADDR) begin
                if (pwrite)
                    bits_in_use = pwdata[bba_pkg::CNT_W-1:0];
                else if (prdata !== 32'(bits_in_use))
                    report_mismatch("bits_in_use readback", prdata, bits_in_use);
            end

            // request transfer: predict now, in order
            if (s_tvalid && s_tready) begin
                expected_results.push_back(bitmap_apply(bba_pkg::op_t'(s_tuser),
                                                        s_tdata[11:0], s_tdata[12]));
                n_req <= n_req + 1;
            end

            // result transfer: compare with the oldest prediction
            if (m_tvalid && m_tready) begin
                n_res <= n_res + 1;
                got.error    = m_tuser[0];
                got.bit_read = m_tdata[0];
                got.found    = m_tdata[12:1];
                got.ubyte    = m_tdata[20:13];
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no request outstanding", 1, 0);
                end else begin
                    want_r = expected_results.pop_front();
                    if (got.error !== want_r.error)
                        report_mismatch("error", got.error, want_r.error);
                    if (got.bit_read !== want_r.bit_read)
                        report_mismatch("bit_read", got.bit_read, want_r.bit_read);
                    if (got.found !== want_r.found)
                        report_mismatch("found_position", got.found, want_r.found);
                    if (got.ubyte !== want_r.ubyte)
                        report_mismatch("updated_byte", got.ubyte, want_r.ubyte);
                end
            end
        end
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Top of the block bitmap allocator bench: clock, reset, request and result
// traffic, APB programming and the verdict. Depends on bba_pkg and bba_checker.

module testbench;

    localparam logic [1:0] REG_BITS_IN_USE = 2'd0;
    localparam int         CYCLE_LIMIT     = 400_000;
    localparam int         LONG_HOLD       = 200;
    localparam int         HOT_SPAN        = 256;
    localparam int         PHASE_ITEMS     = 150;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [1:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int cycles   = 0;
    int hold_req = 0;
    bit no_idle  = 1'b0;

    block_bitmap_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    bba_checker #(.LIMIT_ADDR(REG_BITS_IN_USE)) u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .fail_count(fail_count), .pending(pending)
    );

    // 100 MHz clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offer one request after a random gap and hold it until the transfer.
    task automatic send_req(input bba_pkg::op_t op, input logic [11:0] pos, input logic want);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, want, pos};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop offering and wait until every request has its result back.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // APB write of bits_in_use, then a read back for the checker.
    task automatic program_limit(input logic [12:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_BITS_IN_USE;
        pwdata  <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result side: random stall per transfer, plus an occasional long hold-off.
    initial begin : result_sink
        int gap;
        int holds_done;
        holds_done = 0;
        forever begin
            if (hold_req != holds_done) begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            gap = no_idle ? 0 : $urandom_range(0, 3);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    initial begin : stimulus
        int          phase;
        int          n;
        int          r;
        int          eff;
        int          hot_base;
        logic [12:0] lim;
        logic [11:0] pos;
        logic        want;
        bba_pkg::op_t op;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty bitmap at reset count, byte edges, last position,
        // long and failing searches, unknown operation.
        send_req(bba_pkg::OP_READ,   12'd0,    1'b0);
        send_req(bba_pkg::OP_SEARCH, 12'd0,    1'b0);
        send_req(bba_pkg::OP_SEARCH, 12'd0,    1'b1);  // no match over the whole map
        send_req(bba_pkg::OP_WRITE,  12'd0,    1'b1);
        send_req(bba_pkg::OP_WRITE,  12'd7,    1'b1);
        send_req(bba_pkg::OP_WRITE,  12'd7,    1'b0);
        send_req(bba_pkg::OP_WRITE,  12'd4095, 1'b1);
        send_req(bba_pkg::OP_READ,   12'd4095, 1'b0);
        send_req(bba_pkg::OP_SEARCH, 12'd1,    1'b1);  // runs to the last word
        send_req(bba_pkg::OP_SEARCH, 12'd4095, 1'b0);
        send_req(bba_pkg::OP_SEARCH, 12'd4095, 1'b1);
        send_req(bba_pkg::OP_NONE,   12'd4095, 1'b1);
        send_req(bba_pkg::OP_NONE,   12'd0,    1'b0);
        send_req(bba_pkg::OP_READ,   12'd2048, 1'b0);

        // zero valid bits: everything fails and the store stays put
        drain();
        program_limit(13'd0);
        send_req(bba_pkg::OP_READ,   12'd0, 1'b0);
        send_req(bba_pkg::OP_WRITE,  12'd0, 1'b0);
        send_req(bba_pkg::OP_SEARCH, 12'd0, 1'b1);

        // count above capacity acts as full capacity
        drain();
        program_limit(13'h1FFF);
        send_req(bba_pkg::OP_READ,  12'd4095, 1'b0);
        send_req(bba_pkg::OP_WRITE, 12'd4095, 1'b0);

        // small map: boundary, search starting at the limit, bounded search
        drain();
        program_limit(13'd100);
        send_req(bba_pkg::OP_READ,   12'd99,  1'b0);
        send_req(bba_pkg::OP_READ,   12'd100, 1'b0);
        send_req(bba_pkg::OP_SEARCH, 12'd100, 1'b0);
        send_req(bba_pkg::OP_SEARCH, 12'd1,   1'b1);
        send_req(bba_pkg::OP_WRITE,  12'd99,  1'b1);
        send_req(bba_pkg::OP_SEARCH, 12'd1,   1'b1);

        // Random phases: writes cluster in a moving window so that runs of
        // ones and zeros build up and searches have to walk across them.
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       lim = 13'd4096;
                1:       lim = 13'($urandom_range(1024, 4095));
                2:       lim = 13'h1FFF;
                3:       lim = 13'd4095;
                4:       lim = 13'($urandom_range(8, 900));
                default: lim = 13'd4096;
            endcase
            eff = (lim > 13'd4096) ? 4096 : int'(lim);
            drain();
            program_limit(lim);
            no_idle  = (phase == 3);
            hot_base = 0;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 50 == 0)
                    hot_base = $urandom_range(0, eff - 1);
                if (n == 60 && (phase == 1 || phase == 4))
                    hold_req++;

                r = $urandom_range(0, 99);
                if (r < 45)
                    pos = 12'(hot_base + $urandom_range(0, HOT_SPAN - 1));
                else if (r < 80)
                    pos = 12'($urandom_range(0, 4095));
                else
                    pos = 12'(eff - 2 + $urandom_range(0, 3));  // around the limit

                r = $urandom_range(0, 99);
                if (r < 20) begin
                    op   = bba_pkg::OP_READ;
                    want = 1'($urandom_range(0, 1));
                end else if (r < 65) begin
                    op   = bba_pkg::OP_WRITE;
                    want = ($urandom_range(0, 99) < 70);
                end else if (r < 95) begin
                    op   = bba_pkg::OP_SEARCH;
                    want = 1'($urandom_range(0, 1));
                end else begin
                    op   = bba_pkg::OP_NONE;
                    want = 1'($urandom_range(0, 1));
                end
                send_req(op, pos, want);
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
